FILE: sv/eoli_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the even-odd lattice index converter
// no dependencies

package eoli_pkg;

	localparam int FIELD_DIMS = 4;
	localparam int COORD_W    = 8;
	localparam int EXT_W      = 9;
	localparam int HALF_W     = 31;
	localparam int DIV_STEPS  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(8);

	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	typedef logic [FIELD_DIMS-1:0][EXT_W-1:0] ext_t;

	typedef struct packed {
		logic              func;
		logic [COORD_W-1:0] coord_in_0;
		logic [COORD_W-1:0] coord_in_1;
		logic [COORD_W-1:0] coord_in_2;
		logic [COORD_W-1:0] coord_in_3;
		logic              parity_in;
		logic [HALF_W-1:0] half_index_in;
	} in_word_t;

	typedef struct packed {
		logic              parity_out;
		logic [HALF_W-1:0] half_index_out;
		logic [COORD_W-1:0] coord_out_0;
		logic [COORD_W-1:0] coord_out_1;
		logic [COORD_W-1:0] coord_out_2;
		logic [COORD_W-1:0] coord_out_3;
		logic              out_of_range;
	} out_word_t;

	// word travelling down the divider chain
	typedef struct packed {
		logic                                 func;
		logic                                 parity_in;
		logic [HALF_W-1:0]                    half;
		logic [FIELD_DIMS-1:0][COORD_W-1:0]   coord_in;
		logic [EXT_W-1:0]                     rem;
		logic [DIV_STEPS-1:0]                 num;
		logic [FIELD_DIMS-1:0][EXT_W-1:0]     coord_dec;
	} div_word_t;

endpackage

FILE: sv/eoli_div_cell.sv
`timescale 1ns / 1ps
// one restoring division step of the mixed-radix decoder chain
// depends on eoli_pkg

module eoli_div_cell #(
	parameter int DIM  = 0,
	parameter int STEP = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [eoli_pkg::EXT_W-1:0] ext,
	input  logic                     v_in,
	input  eoli_pkg::div_word_t      d_in,
	output logic                     v_out,
	output eoli_pkg::div_word_t      d_out
);
	import eoli_pkg::*;

	logic [EXT_W-1:0] rem_src;
	logic [EXT_W:0]   trial;
	logic [EXT_W:0]   diff;
	logic             ge;
	div_word_t        nxt;
	logic             v_q;
	div_word_t        d_q;

	always_comb begin
		// first step of a dimension starts from a clean remainder
		rem_src = (STEP == 0) ? '0 : d_in.rem;
		trial   = {rem_src, d_in.num[DIV_STEPS-1]};
		ge      = (trial >= {1'b0, ext});
		diff    = trial - {1'b0, ext};
		nxt     = d_in;
		nxt.rem = ge ? diff[EXT_W-1:0] : trial[EXT_W-1:0];
		nxt.num = {d_in.num[DIV_STEPS-2:0], ge};
		if (STEP == DIV_STEPS - 1) begin
			nxt.coord_dec[DIM] = nxt.rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign v_out = v_q;
	assign d_out = d_q;

endmodule

FILE: sv/eoli_tail.sv
`timescale 1ns / 1ps
// parity fixup, lexicographic encode and volume check, three stages
// depends on eoli_pkg

module eoli_tail (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  eoli_pkg::ext_t      ext,
	input  logic                v_in,
	input  eoli_pkg::div_word_t d_in,
	output logic                v_out,
	output eoli_pkg::out_word_t d_out
);
	import eoli_pkg::*;

	logic [FIELD_DIMS-1:0][EXT_W-1:0]   cin;
	logic [FIELD_DIMS-1:0][COORD_W-1:0] cnew;
	logic                               par_dec;
	logic                               par_enc;
	logic                               inc;
	logic                               carry;
	logic                               oor_enc;
	logic [EXT_W-1:0]                   bumped;

	logic                               v_s1, v_s2, v_s3;
	logic                               func_s1, func_s2;
	logic                               oor0_s1, oor0_s2;
	logic                               par0_s1, par0_s2;
	logic [COORD_W-1:0]                 c0_s1, c0_s2, c1_s1;
	logic [16:0]                        t2_s1;
	logic [25:0]                        t1_s2;
	logic [FIELD_DIMS-1:0][COORD_W-1:0] cdec_s1, cdec_s2;
	logic [DIV_STEPS-1:0]               lex1_s1, lex1_s2;
	logic [17:0]                        p01_s1, p23_s1;
	logic [35:0]                        vol_s2;
	out_word_t                          out_s3;

	logic [34:0]                        lex0;
	logic                               oor_dec;

	always_comb begin
		par_dec = 1'b0;
		par_enc = 1'b0;
		oor_enc = 1'b0;
		for (int d = 0; d < FIELD_DIMS; d++) begin
			par_dec = par_dec ^ d_in.coord_dec[d][0];
			cin[d]  = {1'b0, d_in.coord_in[d]};
			par_enc = par_enc ^ cin[d][0];
			oor_enc = oor_enc | (cin[d] >= ext[d]);
		end
		// wrong parity: step to the next site, mixed-radix increment
		inc   = par_dec ^ d_in.parity_in;
		carry = inc;
		for (int d = 0; d < FIELD_DIMS; d++) begin
			bumped = d_in.coord_dec[d] + EXT_W'(1);
			if (carry && bumped == ext[d]) begin
				cnew[d] = '0;
			end else if (carry) begin
				cnew[d] = bumped[COORD_W-1:0];
				carry   = 1'b0;
			end else begin
				cnew[d] = d_in.coord_dec[d][COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		lex0    = 35'(c0_s2) + 35'(ext[0] * t1_s2);
		oor_dec = ({4'b0, lex1_s2} >= vol_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= d_in.func;
			oor0_s1 <= oor_enc;
			par0_s1 <= par_enc;
			c0_s1   <= d_in.coord_in[0];
			c1_s1   <= d_in.coord_in[1];
			t2_s1   <= 17'(d_in.coord_in[2]) + 17'(ext[2] * d_in.coord_in[3]);
			cdec_s1 <= cnew;
			lex1_s1 <= {d_in.half, inc};
			p01_s1  <= ext[0] * ext[1];
			p23_s1  <= ext[2] * ext[3];

			func_s2 <= func_s1;
			oor0_s2 <= oor0_s1;
			par0_s2 <= par0_s1;
			c0_s2   <= c0_s1;
			t1_s2   <= 26'(c1_s1) + 26'(ext[1] * t2_s1);
			cdec_s2 <= cdec_s1;
			lex1_s2 <= lex1_s1;
			vol_s2  <= p01_s1 * p23_s1;

			if (func_s2 == FUNC_ENCODE) begin
				out_s3.parity_out     <= par0_s2;
				out_s3.half_index_out <= lex0[HALF_W:1];
				out_s3.coord_out_0    <= '0;
				out_s3.coord_out_1    <= '0;
				out_s3.coord_out_2    <= '0;
				out_s3.coord_out_3    <= '0;
				out_s3.out_of_range   <= oor0_s2;
			end else begin
				out_s3.parity_out     <= 1'b0;
				out_s3.half_index_out <= '0;
				out_s3.coord_out_0    <= cdec_s2[0];
				out_s3.coord_out_1    <= cdec_s2[1];
				out_s3.coord_out_2    <= cdec_s2[2];
				out_s3.coord_out_3    <= cdec_s2[3];
				out_s3.out_of_range   <= oor_dec;
			end
		end
	end

	assign v_out = v_s3;
	assign d_out = out_s3;

endmodule

FILE: sv/even_odd_lattice_index_converter_core.sv
`timescale 1ns / 1ps
// even-odd lattice index converter: a word passes 128 division-step cells, three tail
// stages and the output buffer from accept to out_valid; one word per cycle sustained
// while the output buffer is not full, set by the chain of single-step divider cells.
// input stalls only when the two-entry output buffer is full.
// reset clears all valid bits and sets every extent register to 8.
// depends on eoli_pkg, eoli_div_cell, eoli_tail

module even_odd_lattice_index_converter_core #(
	parameter int NUM_DIMS    = 4,
	parameter int EXTENT_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  eoli_pkg::in_word_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output eoli_pkg::out_word_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [eoli_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [eoli_pkg::EXT_W-1:0]    cfg_data
);
	import eoli_pkg::*;

	localparam int ACTIVE  = (NUM_DIMS < FIELD_DIMS) ? NUM_DIMS : FIELD_DIMS;
	localparam int MAX_EXT = 1 << EXTENT_BITS;
	localparam int NCELLS  = FIELD_DIMS * DIV_STEPS;

	ext_t        extent_q;
	ext_t        ext_eff;
	logic        en;
	div_word_t   head;
	div_word_t   chain_d [0:NCELLS];
	logic        chain_v [0:NCELLS];
	logic        tail_v;
	out_word_t   tail_d;
	out_word_t   buf0_q, buf1_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < FIELD_DIMS; d++) begin
				extent_q[d] <= EXT_RESET;
			end
		end else if (cfg_valid) begin
			extent_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int d = 0; d < FIELD_DIMS; d++) begin
			if (d >= ACTIVE || extent_q[d] == '0) begin
				ext_eff[d] = EXT_W'(1);
			end else if (32'(extent_q[d]) > MAX_EXT) begin
				ext_eff[d] = EXT_W'(MAX_EXT);
			end else begin
				ext_eff[d] = extent_q[d];
			end
		end
	end

	// pipeline advances while the output buffer has room
	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;

	always_comb begin
		head.func          = in_data.func;
		head.parity_in     = in_data.parity_in;
		head.half          = in_data.half_index_in;
		head.coord_in[0]   = in_data.coord_in_0;
		head.coord_in[1]   = in_data.coord_in_1;
		head.coord_in[2]   = in_data.coord_in_2;
		head.coord_in[3]   = in_data.coord_in_3;
		// inactive dimensions read as coordinate 0
		for (int d = 0; d < FIELD_DIMS; d++) begin
			if (d >= ACTIVE) begin
				head.coord_in[d] = '0;
			end
		end
		head.rem       = '0;
		head.num       = {in_data.half_index_in, 1'b0};
		head.coord_dec = '0;
	end

	assign chain_d[0] = head;
	assign chain_v[0] = in_valid;

	for (genvar k = 0; k < NCELLS; k++) begin : g_cell
		localparam int DIM  = k / DIV_STEPS;
		localparam int STEP = k % DIV_STEPS;
		eoli_div_cell #(
			.DIM  (DIM),
			.STEP (STEP)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ext    (ext_eff[DIM]),
			.v_in   (chain_v[k]),
			.d_in   (chain_d[k]),
			.v_out  (chain_v[k+1]),
			.d_out  (chain_d[k+1])
		);
	end

	eoli_tail u_tail (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ext    (ext_eff),
		.v_in   (chain_v[NCELLS]),
		.d_in   (chain_d[NCELLS]),
		.v_out  (tail_v),
		.d_out  (tail_d)
	);

	// two-word output buffer
	assign push      = en && tail_v;
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = buf0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				buf0_q <= tail_d;
			end else begin
				buf1_q <= tail_d;
			end
		end else if (pop && !push) begin
			buf0_q <= buf1_q;
		end else if (pop && push) begin
			buf0_q <= tail_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !out_ready) |=> (cnt_q == 2'd2 && $stable(out_data)))
		else $error("full output buffer changed without a pop");

	a_enc_coords: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.half_index_out != '0) |->
		(out_data.coord_out_0 == '0 && out_data.coord_out_1 == '0 &&
		 out_data.coord_out_2 == '0 && out_data.coord_out_3 == '0))
		else $error("encode word carries decoded coordinates");

endmodule
